// File: rtl/smf_pkg.sv
`timescale 1ns / 1ps

package smf_pkg;

  localparam int MAX_PATTERN = 16;
  localparam int BYTE_W      = 8;
  localparam int CFG_W       = 64;
  localparam int LEN_W       = $clog2(MAX_PATTERN + 1);
  localparam int WIN_IDX_W   = $clog2(MAX_PATTERN);
  localparam int POS_W       = 31;

  localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};

  // Register indexes on the configuration port.
  typedef enum logic [1:0] {
    CFG_PATTERN_LOW     = 2'd0,
    CFG_PATTERN_HIGH    = 2'd1,
    CFG_PATTERN_LENGTH  = 2'd2,
    CFG_NON_OVERLAPPING = 2'd3
  } smf_cfg_idx_t;

  // Pattern as the matcher sees it.
  typedef struct packed {
    logic [CFG_W-1:0] pattern_high;
    logic [CFG_W-1:0] pattern_low;
    logic [LEN_W-1:0] length;
  } smf_pat_t;

  // Window control from the top level.
  typedef struct packed {
    logic shift;
    logic clear;
  } smf_win_ctl_t;

  // Clamp the programmed length to the window depth.
  function automatic logic [LEN_W-1:0] sat_len(input logic [LEN_W-1:0] len);
    if (len > LEN_W'(MAX_PATTERN)) begin
      return LEN_W'(MAX_PATTERN);
    end
    return len;
  endfunction

endpackage

// File: rtl/smf_if.sv
`timescale 1ns / 1ps

interface smf_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       last_byte;

  modport source (output valid, output text_byte, output last_byte, input ready);
  modport sink   (input valid, input text_byte, input last_byte, output ready);
endinterface

interface smf_out_if;
  logic        valid;
  logic        ready;
  logic        found;
  logic [30:0] match_start;
  logic        text_done;

  modport source (output valid, output found, output match_start, output text_done,
                  input ready);
  modport sink   (input valid, input found, input match_start, input text_done,
                  output ready);
endinterface

// File: rtl/substring_match_finder.sv
`timescale 1ns / 1ps

// Streaming search for a programmed byte pattern of up to 16 bytes.
//
// Program the pattern through the cfg_ write port while the block is idle:
// pattern_low / pattern_high hold bytes 0..15 (byte 0 in the low bits),
// pattern_length selects how many are used (0 turns matching off, values
// above 16 act as 16), non_overlapping skips past each reported match.
//
// Feed one text byte per request on in_ch; raise last_byte on the final byte
// of a text. A result request on out_ch appears for every byte where a match
// ends (found = 1, match_start = offset of its first byte) and always for the
// last byte (text_done = 1). Other bytes produce no result.
//
// A byte accepted from in_ch sits in the input register, passes the window
// compare and lands in the result register when the input register advances.
// Throughput is one byte per cycle while out_ch does not stall; the window
// compare and position update sit in the single stage between the two registers.
// When out_ch stalls, the result register holds and the input register takes
// one more byte before in_ch.ready drops.
// Reset (synchronous, active low) clears both valid flags, the byte window, the
// text position, the non-overlapping start limit and all configuration registers.

module substring_match_finder (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  smf_pkg::smf_cfg_idx_t            cfg_idx,
  input  logic [smf_pkg::CFG_W-1:0]        cfg_data,
  smf_in_if.sink                           in_ch,
  smf_out_if.source                        out_ch
);
  import smf_pkg::*;

  // Configuration registers.
  logic [CFG_W-1:0] pat_low_r;
  logic [CFG_W-1:0] pat_high_r;
  logic [LEN_W-1:0] pat_len_r;
  logic             non_ovl_r;

  // Input register.
  logic              a_vld_r;
  logic [BYTE_W-1:0] a_byte_r;
  logic              a_last_r;
  logic              a_adv;

  // Text state.
  logic [POS_W-1:0]  pos_r,  pos_nxt;
  logic [POS_W-1:0]  ens_r,  ens_nxt;

  // Result register.
  logic              out_vld_r;
  logic              out_found_r;
  logic [POS_W-1:0]  out_start_r;
  logic              out_done_r;

  smf_pat_t          pat;
  smf_win_ctl_t      win_ctl;
  logic              hit;
  logic [LEN_W-1:0]  len_eff;
  logic [POS_W:0]    len_x;
  logic [POS_W:0]    seen;
  logic [POS_W:0]    start_w;
  logic [POS_W-1:0]  start;
  logic [POS_W:0]    limit_w;
  logic              allowed;
  logic              found;
  logic              emit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_low_r  <= '0;
      pat_high_r <= '0;
      pat_len_r  <= '0;
      non_ovl_r  <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_PATTERN_LOW:     pat_low_r  <= cfg_data;
        CFG_PATTERN_HIGH:    pat_high_r <= cfg_data;
        CFG_PATTERN_LENGTH:  pat_len_r  <= cfg_data[LEN_W-1:0];
        CFG_NON_OVERLAPPING: non_ovl_r  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Advance the input register whenever the result register is free or drains.
  assign a_adv       = a_vld_r && (!out_vld_r || out_ch.ready);
  assign in_ch.ready = !a_vld_r || a_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else if (in_ch.ready) begin
      a_vld_r <= in_ch.valid;
    end
    if (in_ch.ready && in_ch.valid) begin
      a_byte_r <= in_ch.text_byte;
      a_last_r <= in_ch.last_byte;
    end
  end

  assign pat.pattern_low  = pat_low_r;
  assign pat.pattern_high = pat_high_r;
  assign pat.length       = pat_len_r;

  // Shift the window as each byte leaves the input register; wipe it at text
  // end and during reset.
  assign win_ctl.shift = a_adv;
  assign win_ctl.clear = !rst_n || (a_adv && a_last_r);

  smf_matcher u_matcher (
    .clk     (clk),
    .ctl     (win_ctl),
    .byte_in (a_byte_r),
    .pat     (pat),
    .hit     (hit)
  );

  // Match offset bookkeeping: seen counts bytes of this text including this one.
  assign len_eff = sat_len(pat_len_r);
  assign len_x   = {{(POS_W + 1 - LEN_W){1'b0}}, len_eff};
  assign seen    = {1'b0, pos_r} + (POS_W + 1)'(1);
  assign start_w = seen - len_x;
  assign start   = start_w[POS_W-1:0];
  assign limit_w = {1'b0, start} + len_x;
  assign allowed = !non_ovl_r || (start >= ens_r);
  // hit already implies a nonzero length.
  assign found   = hit && (seen >= len_x) && allowed;
  assign emit    = found || a_last_r;

  always_comb begin
    pos_nxt = pos_r;
    ens_nxt = ens_r;
    if (found) begin
      ens_nxt = limit_w[POS_W] ? POS_MAX : limit_w[POS_W-1:0];
    end
    if (pos_r != POS_MAX) begin
      pos_nxt = pos_r + POS_W'(1);
    end
    if (a_last_r) begin
      pos_nxt = '0;
      ens_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      ens_r <= '0;
    end else if (a_adv) begin
      pos_r <= pos_nxt;
      ens_r <= ens_nxt;
    end
  end

  // Load a result when the byte produces one; drop valid once it is taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (a_adv) begin
      out_vld_r <= emit;
    end else if (out_ch.ready) begin
      out_vld_r <= 1'b0;
    end
    if (a_adv) begin
      out_found_r <= found;
      out_start_r <= found ? start : '0;
      out_done_r  <= a_last_r;
    end
  end

  assign out_ch.valid       = out_vld_r;
  assign out_ch.found       = out_found_r;
  assign out_ch.match_start = out_start_r;
  assign out_ch.text_done   = out_done_r;

  // Text end returns the position and the start limit to zero.
  assert property (@(posedge clk) disable iff (!rst_n)
    a_adv && a_last_r |=> pos_r == '0 && ens_r == '0)
    else $error("text state not cleared after last byte");

  // A byte with neither match nor text end leaves no result behind.
  assert property (@(posedge clk) disable iff (!rst_n)
    a_adv && !found && !a_last_r |=> !out_vld_r)
    else $error("result produced without match or text end");

  // Within a text the position never moves backward.
  assert property (@(posedge clk) disable iff (!rst_n)
    a_adv && !a_last_r |=> pos_r >= $past(pos_r))
    else $error("byte position went backward");

  // A reported match always has a pattern enabled.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && out_found_r |-> pat_len_r != '0)
    else $error("match reported with empty pattern");

endmodule

// File: rtl/smf_matcher.sv
`timescale 1ns / 1ps

module smf_matcher (
  input  logic                            clk,
  input  smf_pkg::smf_win_ctl_t           ctl,
  input  logic [smf_pkg::BYTE_W-1:0]      byte_in,
  input  smf_pkg::smf_pat_t               pat,
  output logic                            hit
);
  import smf_pkg::*;

  logic [BYTE_W-1:0]           win_r   [MAX_PATTERN];
  logic [BYTE_W-1:0]           win_nxt [MAX_PATTERN];
  logic [2*CFG_W-1:0]          pat_bytes;
  logic [LEN_W-1:0]            len_eff;

  assign pat_bytes = {pat.pattern_high, pat.pattern_low};
  assign len_eff   = sat_len(pat.length);

  // Window after this byte: newest byte at entry 0.
  always_comb begin
    win_nxt[0] = byte_in;
    for (int j = 1; j < MAX_PATTERN; j++) begin
      win_nxt[j] = win_r[j-1];
    end
  end

  // Entry j of the window lines up with pattern byte len-1-j.
  always_comb begin
    logic [LEN_W-1:0]     ridx;
    logic [WIN_IDX_W-1:0] pidx;
    logic                 ok;
    ok = (len_eff != '0);
    for (int j = 0; j < MAX_PATTERN; j++) begin
      ridx = len_eff - LEN_W'(1) - LEN_W'(j);
      pidx = ridx[WIN_IDX_W-1:0];
      if (LEN_W'(j) < len_eff && win_nxt[j] != pat_bytes[BYTE_W*pidx +: BYTE_W]) begin
        ok = 1'b0;
      end
    end
    hit = ok;
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < MAX_PATTERN; j++) begin
      if (ctl.clear) begin
        win_r[j] <= '0;
      end else if (ctl.shift) begin
        win_r[j] <= win_nxt[j];
      end
    end
  end

endmodule
